// ----- src/efpf_pkg.sv -----
`default_nettype none
package efpf_pkg;

  // frame byte counter
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // header byte positions
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_V4_PROTO  = 6'd23;
  localparam logic [POS_W-1:0] POS_V6_NEXT   = 6'd20;
  localparam logic [POS_W-1:0] POS_V4_PORTS  = 6'd34;
  localparam logic [POS_W-1:0] POS_V6_PORTS  = 6'd54;
  localparam logic [POS_W-1:0] POS_PORTS_LEN = 6'd4;

  // ethertypes and protocol numbers
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    FK_IPV4  = 2'd0,
    FK_ARP   = 2'd1,
    FK_IPV6  = 2'd2,
    FK_OTHER = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    TK_ICMP = 2'd0,
    TK_TCP  = 2'd1,
    TK_UDP  = 2'd2,
    TK_NONE = 2'd3
  } transport_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ICMP_EN    = 3'd0,
    REG_TCP_EN     = 3'd1,
    REG_UDP_EN     = 3'd2,
    REG_ARP_EN     = 3'd3,
    REG_PORT_MATCH = 3'd4,
    REG_MATCH_PORT = 3'd5
  } cfg_reg_t;

  // one classified frame, front to back
  typedef struct packed {
    frame_kind_t frame_kind;
    logic [7:0]  proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        eth_short;
    logic        proto_short;
    logic        ports_short;
  } frame_rec_t;

  // queue control from the front
  typedef struct packed {
    logic push;
  } queue_ctl_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// ----- src/efpf_ifs.sv -----
`default_nettype none
interface efpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface efpf_verdict_if;
  logic        valid;
  logic        ready;
  logic        accept;
  logic [1:0]  frame_kind;
  logic [1:0]  transport_kind;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic        too_short;
  modport source (output valid, output accept, output frame_kind, output transport_kind,
                  output source_port, output destination_port, output too_short,
                  input ready);
  modport sink   (input valid, input accept, input frame_kind, input transport_kind,
                  input source_port, input destination_port, input too_short,
                  output ready);
endinterface

interface efpf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [efpf_pkg::CFG_IDX_W-1:0]   index;
  logic [efpf_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/ethernet_frame_protocol_port_filter.sv -----
// Ethernet protocol and port filter. Frame bytes enter on the frame channel, one per
// cycle while the channel is not stalled, with no gaps needed, starting at the
// destination MAC; the byte flagged last_byte closes the frame and yields one verdict
// on the verdict channel. The frame is classified as its last byte transfers and
// enters a two-entry queue on that edge; the verdict register loads from the queue
// whenever it is empty or its verdict is being taken. The frame channel stalls only
// when two finished frames wait in the queue. The EtherType is read at bytes 12-13;
// IPv4 assumes a 20-byte header (protocol at byte 23, ports at 34-37), IPv6 reads
// next-header at byte 20 and ports at 54-57. The configuration channel is always
// ready; write it only while no frame is in flight.
`default_nettype none
module ethernet_frame_protocol_port_filter (
  input  wire             clk,
  input  wire             rst,
  efpf_byte_if.sink       frame,
  efpf_verdict_if.source  verdict,
  efpf_cfg_if.sink        cfg
);

  efpf_pkg::queue_ctl_t  ctl;
  efpf_pkg::frame_rec_t  wr_rec, rd_rec;
  logic                  full, rd_valid, rd_pop;

  // byte parser
  efpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .queue_full (full),
    .ctl        (ctl),
    .rec        (wr_rec)
  );

  // finished-frame queue
  efpf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .wr_rec   (wr_rec),
    .full     (full),
    .rd_valid (rd_valid),
    .rd_pop   (rd_pop),
    .rd_rec   (rd_rec)
  );

  // verdict stage
  efpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rd_valid),
    .rec       (rd_rec),
    .rec_pop   (rd_pop),
    .verdict   (verdict)
  );

endmodule
`default_nettype wire

// ----- src/efpf_front.sv -----
`default_nettype none
module efpf_front (
  input  wire                    clk,
  input  wire                    rst,
  efpf_byte_if.sink              frame,
  input  wire                    queue_full,
  output efpf_pkg::queue_ctl_t   ctl,
  output efpf_pkg::frame_rec_t   rec
);

  logic [efpf_pkg::POS_W-1:0] pos;
  logic [15:0] etype, etype_next;
  logic [7:0]  proto, proto_next;
  logic [15:0] sport, sport_next;
  logic [15:0] dport, dport_next;
  logic        is_v4, is_v6, is_v4_next, is_v6_next;
  logic        xfer;
  logic [efpf_pkg::POS_W-1:0] pbase;

  assign frame.ready = !queue_full;
  assign xfer        = frame.valid && frame.ready;

  assign is_v4 = (etype == efpf_pkg::ETYPE_IPV4);
  assign is_v6 = (etype == efpf_pkg::ETYPE_IPV6);
  assign pbase = is_v6 ? efpf_pkg::POS_V6_PORTS : efpf_pkg::POS_V4_PORTS;

  // field capture at fixed byte positions
  always_comb begin
    etype_next = etype;
    proto_next = proto;
    sport_next = sport;
    dport_next = dport;
    if (pos == efpf_pkg::POS_ETYPE_HI) etype_next[15:8] = frame.data_byte;
    if (pos == efpf_pkg::POS_ETYPE_LO) etype_next[7:0]  = frame.data_byte;
    if ((is_v4 && pos == efpf_pkg::POS_V4_PROTO) || (is_v6 && pos == efpf_pkg::POS_V6_NEXT))
      proto_next = frame.data_byte;
    if (is_v4 || is_v6) begin
      if (pos == pbase)                      sport_next[15:8] = frame.data_byte;
      if (pos == pbase + 6'd1)               sport_next[7:0]  = frame.data_byte;
      if (pos == pbase + 6'd2)               dport_next[15:8] = frame.data_byte;
      if (pos == pbase + 6'd3)               dport_next[7:0]  = frame.data_byte;
    end
  end

  assign is_v4_next = (etype_next == efpf_pkg::ETYPE_IPV4);
  assign is_v6_next = (etype_next == efpf_pkg::ETYPE_IPV6);

  // classify the frame on its last byte
  always_comb begin
    rec.proto       = proto_next;
    rec.src_port    = sport_next;
    rec.dst_port    = dport_next;
    rec.eth_short   = (pos < efpf_pkg::POS_ETYPE_LO);
    rec.proto_short = is_v4_next ? (pos < efpf_pkg::POS_V4_PROTO)
                                 : (pos < efpf_pkg::POS_V6_NEXT);
    rec.ports_short = is_v4_next
                    ? (pos < efpf_pkg::POS_V4_PORTS + efpf_pkg::POS_PORTS_LEN - 6'd1)
                    : (pos < efpf_pkg::POS_V6_PORTS + efpf_pkg::POS_PORTS_LEN - 6'd1);
    if (rec.eth_short)                           rec.frame_kind = efpf_pkg::FK_OTHER;
    else if (is_v4_next)                         rec.frame_kind = efpf_pkg::FK_IPV4;
    else if (is_v6_next)                         rec.frame_kind = efpf_pkg::FK_IPV6;
    else if (etype_next == efpf_pkg::ETYPE_ARP)  rec.frame_kind = efpf_pkg::FK_ARP;
    else                                         rec.frame_kind = efpf_pkg::FK_OTHER;
  end

  assign ctl.push = xfer && frame.last_byte;

  // per-frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      etype <= '0;
      proto <= '0;
      sport <= '0;
      dport <= '0;
    end else if (xfer) begin
      if (frame.last_byte) begin
        pos   <= '0;
        etype <= '0;
        proto <= '0;
        sport <= '0;
        dport <= '0;
      end else begin
        if (pos != efpf_pkg::POS_MAX) pos <= pos + 6'd1;
        etype <= etype_next;
        proto <= proto_next;
        sport <= sport_next;
        dport <= dport_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/efpf_queue.sv -----
`default_nettype none
module efpf_queue (
  input  wire                        clk,
  input  wire                        rst,
  input  wire efpf_pkg::queue_ctl_t  ctl,
  input  wire efpf_pkg::frame_rec_t  wr_rec,
  output logic                       full,
  output logic                       rd_valid,
  input  wire                        rd_pop,
  output efpf_pkg::frame_rec_t       rd_rec
);

  efpf_pkg::frame_rec_t mem [efpf_pkg::QUEUE_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(efpf_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_rec   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr_ptr] <= wr_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (ctl.push) wr_ptr <= !wr_ptr;
      if (rd_pop)   rd_ptr <= !rd_ptr;
      case ({ctl.push, rd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/efpf_back.sv -----
`default_nettype none
module efpf_back (
  input  wire                        clk,
  input  wire                        rst,
  efpf_cfg_if.sink                   cfg,
  input  wire                        rec_valid,
  input  wire efpf_pkg::frame_rec_t  rec,
  output logic                       rec_pop,
  efpf_verdict_if.source             verdict
);

  logic        icmp_en, tcp_en, udp_en, arp_en, port_match_en;
  logic [15:0] match_port;

  logic                        accept_next;
  efpf_pkg::transport_kind_t   tkind_next;
  logic [15:0]                 sport_next, dport_next;
  logic                        short_next;
  logic                        l4_en;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      icmp_en       <= 1'b1;
      tcp_en        <= 1'b1;
      udp_en        <= 1'b1;
      arp_en        <= 1'b1;
      port_match_en <= 1'b0;
      match_port    <= '0;
    end else if (cfg.valid) begin
      case (efpf_pkg::cfg_reg_t'(cfg.index))
        efpf_pkg::REG_ICMP_EN:    icmp_en       <= cfg.data[0];
        efpf_pkg::REG_TCP_EN:     tcp_en        <= cfg.data[0];
        efpf_pkg::REG_UDP_EN:     udp_en        <= cfg.data[0];
        efpf_pkg::REG_ARP_EN:     arp_en        <= cfg.data[0];
        efpf_pkg::REG_PORT_MATCH: port_match_en <= cfg.data[0];
        efpf_pkg::REG_MATCH_PORT: match_port    <= cfg.data;
        default: ;
      endcase
    end
  end

  // verdict
  always_comb begin
    accept_next = 1'b0;
    tkind_next  = efpf_pkg::TK_NONE;
    sport_next  = '0;
    dport_next  = '0;
    short_next  = 1'b0;
    l4_en       = (rec.proto == efpf_pkg::PROTO_TCP) ? tcp_en : udp_en;
    if (rec.eth_short) begin
      short_next = 1'b1;
    end else begin
      case (rec.frame_kind)
        efpf_pkg::FK_ARP: accept_next = arp_en;
        efpf_pkg::FK_IPV4, efpf_pkg::FK_IPV6: begin
          if (rec.proto_short) begin
            short_next = 1'b1;
          end else if (rec.proto == efpf_pkg::PROTO_ICMP) begin
            tkind_next  = efpf_pkg::TK_ICMP;
            accept_next = icmp_en;
          end else if (rec.proto == efpf_pkg::PROTO_TCP ||
                       rec.proto == efpf_pkg::PROTO_UDP) begin
            tkind_next = (rec.proto == efpf_pkg::PROTO_TCP) ? efpf_pkg::TK_TCP
                                                           : efpf_pkg::TK_UDP;
            if (rec.ports_short) begin
              short_next = 1'b1;
            end else begin
              sport_next  = rec.src_port;
              dport_next  = rec.dst_port;
              accept_next = l4_en && (!port_match_en || rec.src_port == match_port ||
                                      rec.dst_port == match_port);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign rec_pop = rec_valid && (!verdict.valid || verdict.ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (!verdict.valid || verdict.ready) begin
      verdict.valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      verdict.accept           <= accept_next;
      verdict.frame_kind       <= rec.frame_kind;
      verdict.transport_kind   <= tkind_next;
      verdict.source_port      <= sport_next;
      verdict.destination_port <= dport_next;
      verdict.too_short        <= short_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/efpf_checker.sv -----
`default_nettype none
module efpf_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire in_last,
  input wire out_valid,
  input wire out_ready,
  input wire out_accept,
  input wire out_too_short
);

  logic [2:0] pending;

  // frames closed but whose verdict is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      case ({in_valid && in_ready && in_last, out_valid && out_ready})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  // stalled verdict stays up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // no verdict right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("verdict valid after reset");

  // every verdict belongs to a closed frame
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("verdict without a closed frame");

  // with nothing in flight the byte side is free
  assert property (@(posedge clk) disable iff (rst)
    pending == 3'd0 |-> in_ready)
    else $error("byte channel stalled while empty");

  // a short frame never passes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_too_short |-> !out_accept)
    else $error("short frame accepted");

endmodule

bind ethernet_frame_protocol_port_filter efpf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (frame.valid),
  .in_ready      (frame.ready),
  .in_last       (frame.last_byte),
  .out_valid     (verdict.valid),
  .out_ready     (verdict.ready),
  .out_accept    (verdict.accept),
  .out_too_short (verdict.too_short)
);
`default_nettype wire
